// ===== hdl/nsf_pkg.sv =====
// Package for the NMEA sentence framer: character codes, the status encoding,
// the framing result record and the reset defaults. No dependencies.
package nsf_pkg;

   localparam int unsigned LimitWidth         = 7;
   localparam int unsigned ByteWidth          = 8;
   localparam int unsigned CountOutWidth      = 32;
   localparam int unsigned CounterWidthDefault = 32;
   localparam logic [LimitWidth-1:0] LimitReset = 7'd82;

   localparam logic [ByteWidth-1:0] CharDollar  = 8'h24;
   localparam logic [ByteWidth-1:0] CharBang    = 8'h21;
   localparam logic [ByteWidth-1:0] CharLineEnd = 8'h0A;

   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_START    = 3'd1,
      ST_STORED   = 3'd2,
      ST_COMPLETE = 3'd3,
      ST_RESTART  = 3'd4,
      ST_OVERRUN  = 3'd5
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic [LimitWidth-1:0]      position;
      logic [CountOutWidth-1:0]   completion_count;
      logic [CountOutWidth-1:0]   restart_count;
      logic [CountOutWidth-1:0]   overrun_count;
   } frame_result_type;

endpackage

// ===== hdl/nsf_in_stage.sv =====
// Input register of the NMEA sentence framer: captures one byte transaction
// and holds it until the framing stage takes it. Depends on nsf_pkg.
module nsf_in_stage
   import nsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [ByteWidth-1:0] req_in_byte,
   input  logic                 advance,
   output logic                 stage_valid,
   output logic [ByteWidth-1:0] stage_byte
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;

   // load when the stage is free or being drained, hold otherwise
   assign valid_in = advance ? req_valid : valid_ff;
   assign byte_in  = (advance && req_valid) ? req_in_byte : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

endmodule

// ===== hdl/nsf_frame_core.sv =====
// Framing state and decision logic: classifies one byte against the receive
// state and length limit, updates the position and counters. Depends on nsf_pkg.
module nsf_frame_core
   import nsf_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [ByteWidth-1:0]  in_byte,
   input  logic [LimitWidth-1:0] length_limit,
   output frame_result_type      result
);

   logic                     receiving_ff, receiving_in;
   logic [LimitWidth-1:0]    next_pos_ff, next_pos_in;
   logic [COUNTER_WIDTH-1:0] completions_ff, completions_in;
   logic [COUNTER_WIDTH-1:0] restarts_ff, restarts_in;
   logic [COUNTER_WIDTH-1:0] overruns_ff, overruns_in;

   logic                     is_start;
   logic [LimitWidth:0]      pos_plus_one;
   logic                     too_long;
   status_type               status;
   logic [LimitWidth-1:0]    position;
   logic [63:0]              completions_wide, restarts_wide, overruns_wide;

   assign is_start     = (in_byte == CharDollar) || (in_byte == CharBang);
   assign pos_plus_one = {1'b0, next_pos_ff} + 1'b1;
   assign too_long     = pos_plus_one > {1'b0, length_limit};

   always_comb begin
      receiving_in   = receiving_ff;
      next_pos_in    = next_pos_ff;
      completions_in = completions_ff;
      restarts_in    = restarts_ff;
      overruns_in    = overruns_ff;
      status         = ST_IGNORED;
      position       = '0;
      if (!receiving_ff) begin
         if (is_start) begin
            receiving_in = 1'b1;
            next_pos_in  = LimitWidth'(1);
            status       = ST_START;
         end
      end else if (in_byte == CharLineEnd) begin
         completions_in = completions_ff + 1'b1;
         receiving_in   = 1'b0;
         status         = ST_COMPLETE;
         position       = next_pos_ff;
      end else if (is_start) begin
         restarts_in = restarts_ff + 1'b1;
         next_pos_in = LimitWidth'(1);
         status      = ST_RESTART;
      end else if (too_long) begin
         overruns_in  = overruns_ff + 1'b1;
         receiving_in = 1'b0;
         status       = ST_OVERRUN;
         position     = next_pos_ff;
      end else begin
         next_pos_in = pos_plus_one[LimitWidth-1:0];
         status      = ST_STORED;
         position    = next_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff   <= 1'b0;
         next_pos_ff    <= '0;
         completions_ff <= '0;
         restarts_ff    <= '0;
         overruns_ff    <= '0;
      end else if (step) begin
         receiving_ff   <= receiving_in;
         next_pos_ff    <= next_pos_in;
         completions_ff <= completions_in;
         restarts_ff    <= restarts_in;
         overruns_ff    <= overruns_in;
      end
   end

   // report the low bits of the counters after this byte
   assign completions_wide = 64'(completions_in);
   assign restarts_wide    = 64'(restarts_in);
   assign overruns_wide    = 64'(overruns_in);

   assign result.status           = status;
   assign result.position         = position;
   assign result.completion_count = completions_wide[CountOutWidth-1:0];
   assign result.restart_count    = restarts_wide[CountOutWidth-1:0];
   assign result.overrun_count    = overruns_wide[CountOutWidth-1:0];

`ifndef NO_ASSERTIONS
   a_complete_counts: assert property (@(posedge clock) disable iff (reset)
      step && (status == ST_COMPLETE) |=>
         completions_ff == COUNTER_WIDTH'($past(completions_ff) + 1'b1))
      else $error("completion counter did not advance on a completed sentence");

   a_overrun_drops: assert property (@(posedge clock) disable iff (reset)
      step && (status == ST_OVERRUN) |=> !receiving_ff)
      else $error("framer still receiving after an overrun");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(receiving_ff) && $stable(next_pos_ff) && $stable(overruns_ff))
      else $error("framing state changed without a byte");

   a_restart_position: assert property (@(posedge clock) disable iff (reset)
      step && (status == ST_START || status == ST_RESTART) |=> next_pos_ff == LimitWidth'(1))
      else $error("start of sentence did not reset the position");
`endif

endmodule

// ===== hdl/nmea_sentence_framer_unit.sv =====
// Top level of the NMEA sentence framer: length-limit register, input stage,
// framing core and result register. Depends on nsf_pkg, nsf_in_stage, nsf_frame_core.
//
// Usage:
//   req_ channel carries one received byte per transaction (req_in_byte).
//   rsp_ channel returns exactly one result per byte: status, the byte, its
//   sentence position and the completion, restart and overrun counters.
//   csr_write_enable/csr_write_data write the 7-bit length limit (reset 82);
//   write it only while no transaction is in flight.
// Path: a byte accepted into the input register is framed and presented on rsp_
//   from the result register (two register stages: input register, result register).
// Throughput: one byte per cycle while rsp_stall is not holding a result; the framing
//   decision is a few byte compares, a 7-bit add/compare and the counter increments,
//   all combinational between the input register and the result register.
// Reset: synchronous, active high. Clears both stage valids, the receive
//   state, the position and all counters, and reloads the limit to 82.
// Stall: while rsp_stall holds a valid result, the result register holds;
//   one more byte may sit in the input register, after which req_stall rises.
module nmea_sentence_framer_unit
   import nsf_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ByteWidth-1:0]     req_in_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [ByteWidth-1:0]     rsp_out_byte,
   output logic [LimitWidth-1:0]    rsp_position,
   output logic [CountOutWidth-1:0] rsp_completion_count,
   output logic [CountOutWidth-1:0] rsp_restart_count,
   output logic [CountOutWidth-1:0] rsp_overrun_count,
   input  logic                     csr_write_enable,
   input  logic [LimitWidth-1:0]    csr_write_data
);

   logic [LimitWidth-1:0] limit_ff;
   logic [LimitWidth-1:0] limit_in;

   logic                  stage_valid;
   logic [ByteWidth-1:0]  stage_byte;
   logic                  out_free;
   logic                  in_advance;
   logic                  step;
   frame_result_type      result;

   logic                  rsp_valid_ff, rsp_valid_in;
   frame_result_type      rsp_result_ff, rsp_result_in;
   logic [ByteWidth-1:0]  rsp_byte_ff, rsp_byte_in;

   // length limit register
   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // result register drains when empty or taken; input stage advances with it
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_advance = !stage_valid || out_free;
   assign step       = stage_valid && out_free;
   assign req_stall  = !in_advance;

   nsf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .advance     (in_advance),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte)
   );

   nsf_frame_core #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_frame_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .in_byte      (stage_byte),
      .length_limit (limit_ff),
      .result       (result)
   );

   // load a new result on each step, hold it while stalled
   assign rsp_valid_in  = out_free ? stage_valid : rsp_valid_ff;
   assign rsp_result_in = step ? result : rsp_result_ff;
   assign rsp_byte_in   = step ? stage_byte : rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_result_ff.status;
   assign rsp_out_byte         = rsp_byte_ff;
   assign rsp_position         = rsp_result_ff.position;
   assign rsp_completion_count = rsp_result_ff.completion_count;
   assign rsp_restart_count    = rsp_result_ff.restart_count;
   assign rsp_overrun_count    = rsp_result_ff.overrun_count;

`ifndef NO_ASSERTIONS
   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("framed byte did not reach the result register");

   a_no_step_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !step)
      else $error("result overwritten while stalled");

   a_ignored_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_result_ff.status == ST_IGNORED || rsp_result_ff.status == ST_START
         || rsp_result_ff.status == ST_RESTART) |-> rsp_result_ff.position == '0)
      else $error("nonzero position on an ignored, start or restart result");
`endif

endmodule
